// ----- design/sxt_pkg.sv -----
// Shared types, token codes and character classes for the s-expression tokenizer.
`timescale 1ns / 1ps

package sxt_pkg;

    typedef enum logic [2:0] {
        KIND_LPAREN = 3'd0,
        KIND_RPAREN = 3'd1,
        KIND_INT    = 3'd2,
        KIND_ID     = 3'd3,
        KIND_END    = 3'd4,
        KIND_ERROR  = 3'd5
    } token_kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_INT  = 2'd1,
        MODE_ID   = 2'd2
    } scan_mode_t;

    typedef struct packed {
        token_kind_t kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } token_t;

    localparam logic [7:0] CHAR_LPAREN     = 8'h28;
    localparam logic [7:0] CHAR_RPAREN     = 8'h29;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    // letters, operator symbols $ % & * + - . / : < = > ? ^ | ~ and underscore
    function automatic logic is_id_first(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]}) ||
               (c inside {8'h24, 8'h25, 8'h26, 8'h2A, 8'h2B, 8'h2D, 8'h2E, 8'h2F,
                          8'h3A, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h5E, 8'h7C, 8'h7E}) ||
               (c == CHAR_UNDERSCORE);
    endfunction

    function automatic logic is_id_rest(input logic [7:0] c);
        return is_id_first(c) || is_digit(c);
    endfunction

endpackage

// ----- design/s_expression_tokenizer_core.sv -----
// Top level of the s-expression tokenizer: byte classification, scan state and token buffer.
`timescale 1ns / 1ps

// Streaming s-expression lexer. Each input word carries one source byte (or none)
// and an end-of-source flag; each output word is one token with kind, start offset,
// length and a flag marking the last token caused by that input word. An input word
// is classified and the scan state updated in the cycle it is accepted; its tokens
// (zero to three) land in a three-entry output buffer. A new word is taken when the
// buffer is empty or holds one token being taken in the same cycle, so with out_ready
// high the buffer drains one token per cycle and a stream giving at most one token
// per byte runs at one byte per cycle; a word giving more holds the input until its
// last token is taken. Offsets, OFFSET_BITS wide, saturate at 2^OFFSET_BITS - 1; the
// token_start and token_length ports show their low 16 bits. End of source flushes
// any open token, emits an end token and restarts offsets at zero.
module s_expression_tokenizer_core #(
    parameter int OFFSET_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_source,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  token_kind,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic        last_of_run
);

    localparam int SLOTS = 3;
    localparam int CANDS = 4;

    function automatic logic [15:0] to_port(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+15:0] w;
        w = {16'b0, v};
        return w[15:0];
    endfunction

    sxt_pkg::scan_mode_t    mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] open_start_reg, open_start_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [1:0]             count_reg, count_next;
    sxt_pkg::token_t        slot_reg [SLOTS];
    sxt_pkg::token_t        slot_next [SLOTS];

    logic accept, pop;

    // per-byte decode
    logic                   ends_open;
    sxt_pkg::scan_mode_t    mode_a, mode_b;
    logic [OFFSET_BITS-1:0] start_b, offset_after;
    logic                   byte_tok;
    sxt_pkg::token_kind_t   byte_kind;

    sxt_pkg::token_t cand [CANDS];
    logic [CANDS-1:0] cand_v;
    logic [1:0]       n_tok;

    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign in_ready  = (count_reg == 2'd0) || ((count_reg == 2'd1) && out_ready);
    assign accept    = in_valid && in_ready;

    assign token_kind   = slot_reg[0].kind;
    assign token_start  = slot_reg[0].start;
    assign token_length = slot_reg[0].length;
    assign last_of_run  = slot_reg[0].last;

    // next state
    always_comb
    begin
        ends_open    = 1'b0;
        mode_a       = mode_reg;
        mode_b       = mode_reg;
        start_b      = open_start_reg;
        offset_after = offset_reg;
        byte_tok     = 1'b0;
        byte_kind    = sxt_pkg::KIND_ERROR;
        if (byte_present)
        begin
            case (mode_reg)
                sxt_pkg::MODE_INT: ends_open = !sxt_pkg::is_digit(data_byte);
                sxt_pkg::MODE_ID:  ends_open = !sxt_pkg::is_id_rest(data_byte);
                default:           ends_open = 1'b0;
            endcase
            mode_a = ends_open ? sxt_pkg::MODE_IDLE : mode_reg;
            if (mode_a != sxt_pkg::MODE_INT && mode_a != sxt_pkg::MODE_ID)
                mode_a = sxt_pkg::MODE_IDLE;
            mode_b = mode_a;
            if (mode_a == sxt_pkg::MODE_IDLE)
            begin
                if (sxt_pkg::is_space(data_byte))
                begin
                    byte_tok = 1'b0;
                end
                else if (data_byte == sxt_pkg::CHAR_LPAREN)
                begin
                    byte_tok  = 1'b1;
                    byte_kind = sxt_pkg::KIND_LPAREN;
                end
                else if (data_byte == sxt_pkg::CHAR_RPAREN)
                begin
                    byte_tok  = 1'b1;
                    byte_kind = sxt_pkg::KIND_RPAREN;
                end
                else if (sxt_pkg::is_digit(data_byte))
                begin
                    mode_b  = sxt_pkg::MODE_INT;
                    start_b = offset_reg;
                end
                else if (sxt_pkg::is_id_first(data_byte))
                begin
                    mode_b  = sxt_pkg::MODE_ID;
                    start_b = offset_reg;
                end
                else
                begin
                    byte_tok  = 1'b1;
                    byte_kind = sxt_pkg::KIND_ERROR;
                end
            end
            if (offset_reg != {OFFSET_BITS{1'b1}})
                offset_after = offset_reg + OFFSET_BITS'(1);
        end

        mode_next       = mode_reg;
        open_start_next = open_start_reg;
        offset_next     = offset_reg;
        if (accept)
        begin
            if (end_of_source)
            begin
                mode_next       = sxt_pkg::MODE_IDLE;
                open_start_next = '0;
                offset_next     = '0;
            end
            else
            begin
                mode_next       = mode_b;
                open_start_next = start_b;
                offset_next     = offset_after;
            end
        end
    end

    // tokens of the accepted word, in emission order
    always_comb
    begin
        logic [1:0] idx;
        idx = 2'd0;

        cand[0].kind   = (mode_reg == sxt_pkg::MODE_INT) ? sxt_pkg::KIND_INT
                                                         : sxt_pkg::KIND_ID;
        cand[0].start  = to_port(open_start_reg);
        cand[0].length = to_port(offset_reg - open_start_reg);
        cand[0].last   = 1'b0;
        cand_v[0]      = ends_open;

        cand[1].kind   = byte_kind;
        cand[1].start  = to_port(offset_reg);
        cand[1].length = 16'd1;
        cand[1].last   = 1'b0;
        cand_v[1]      = byte_tok;

        cand[2].kind   = (mode_b == sxt_pkg::MODE_INT) ? sxt_pkg::KIND_INT
                                                       : sxt_pkg::KIND_ID;
        cand[2].start  = to_port(start_b);
        cand[2].length = to_port(offset_after - start_b);
        cand[2].last   = 1'b0;
        cand_v[2]      = end_of_source &&
                         (mode_b == sxt_pkg::MODE_INT || mode_b == sxt_pkg::MODE_ID);

        cand[3].kind   = sxt_pkg::KIND_END;
        cand[3].start  = to_port(offset_after);
        cand[3].length = 16'd0;
        cand[3].last   = 1'b0;
        cand_v[3]      = end_of_source;

        for (int s = 0; s < SLOTS; s++)
            slot_next[s] = cand[3];

        for (int i = 0; i < CANDS; i++)
        begin
            if (cand_v[i])
            begin
                case (idx)
                    2'd0:    slot_next[0] = cand[i];
                    2'd1:    slot_next[1] = cand[i];
                    2'd2:    slot_next[2] = cand[i];
                    default: slot_next[2] = cand[i];
                endcase
                idx = idx + 2'd1;
            end
        end
        n_tok = idx;

        case (n_tok)
            2'd1:    slot_next[0].last = 1'b1;
            2'd2:    slot_next[1].last = 1'b1;
            2'd3:    slot_next[2].last = 1'b1;
            default: slot_next[0].last = 1'b0;
        endcase

        if (accept)
            count_next = n_tok;
        else if (pop)
            count_next = count_reg - 2'd1;
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= sxt_pkg::MODE_IDLE;
            open_start_reg <= '0;
            offset_reg     <= '0;
            count_reg      <= 2'd0;
        end
        else
        begin
            mode_reg       <= mode_next;
            open_start_reg <= open_start_next;
            offset_reg     <= offset_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int s = 0; s < SLOTS; s++)
                slot_reg[s] <= slot_next[s];
        end
        else if (pop)
        begin
            for (int s = 0; s < SLOTS - 1; s++)
                slot_reg[s] <= slot_reg[s+1];
        end
    end

endmodule
